>>> rtl/octree_child_rms_color_average_defines.svh
// Assertion helpers shared by the RTL.
`ifndef OCTREE_CHILD_RMS_COLOR_AVERAGE_DEFINES_SVH
`define OCTREE_CHILD_RMS_COLOR_AVERAGE_DEFINES_SVH

// Overlapping implication, sampled on the rising clock, off during reset.
`define OCRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define OCRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
        else $error(msg);

`endif

>>> rtl/ocra_pkg.sv
package ocra_pkg;

    localparam int CHILD_INPUTS      = 8;
    localparam int CHILD_COUNT_DEF   = 8;
    localparam int COLOR_W           = 24;
    localparam int CHAN_W            = 8;
    localparam int SQ_W              = 2 * CHAN_W;
    localparam int CNT_MAX_W         = 4;
    // Reciprocal of the set-child count, scaled by 2^RECIP_SHIFT and rounded up.
    // Exact floor quotient for any square sum below 2^20.
    localparam int RECIP_SHIFT       = 23;
    localparam int RECIP_W           = 24;

    typedef struct packed {
        logic [COLOR_W-1:0] child_color_7;
        logic [COLOR_W-1:0] child_color_6;
        logic [COLOR_W-1:0] child_color_5;
        logic [COLOR_W-1:0] child_color_4;
        logic [COLOR_W-1:0] child_color_3;
        logic [COLOR_W-1:0] child_color_2;
        logic [COLOR_W-1:0] child_color_1;
        logic [COLOR_W-1:0] child_color_0;
        logic [COLOR_W-1:0] own_color;
        logic               has_children;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
    } t_out_word;

    // ceil(2^23 / n); zero count maps to zero so the quotient is zero.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_MAX_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 24'd8388608;
            4'd2:    m = 24'd4194304;
            4'd3:    m = 24'd2796203;
            4'd4:    m = 24'd2097152;
            4'd5:    m = 24'd1677722;
            4'd6:    m = 24'd1398102;
            4'd7:    m = 24'd1198373;
            4'd8:    m = 24'd1048576;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/octree_child_rms_color_average.sv
// Octree inner-node color reduction, root mean square of the set children.
//
// Input channel: i_item (one word) is taken at a rising edge where start is
// high and busy is low. busy is high only while i_rst_n is low, so a word can
// be taken in every cycle.
// Output channel: o_result is valid for exactly one cycle, marked by o_strobe.
// The receiver cannot hold results off; none is needed, since the pipeline
// never stalls.
// Pipeline: five register stages; the fifth drives o_strobe and o_result.
// Throughput: one word per cycle. Stages are squares, per-channel sums,
// division by the set-child count (multiply by a reciprocal), then two
// stages of four bit-steps each of the integer square root.
// No children: own_color passes through. No set child: result is zero.
// Reset (synchronous, active low) drops every word in flight; no result
// appears for words taken before reset.
`include "octree_child_rms_color_average_defines.svh"

module octree_child_rms_color_average #(
    parameter int CHILD_COUNT = ocra_pkg::CHILD_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ocra_pkg::t_in_word  i_item,
    output logic                o_strobe,
    output ocra_pkg::t_out_word o_result
);

    localparam int CH_W   = ocra_pkg::CHAN_W;
    localparam int SQ_W   = ocra_pkg::SQ_W;
    localparam int CNT_W  = $clog2(CHILD_COUNT + 1);
    localparam int SUM_W  = SQ_W + $clog2(CHILD_COUNT);
    localparam int PROD_W = SUM_W + ocra_pkg::RECIP_W;
    localparam int RT_W   = SQ_W + 1;   // remainder and root during the root steps
    localparam int NCH    = 3;

    logic accept;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // children as an array for the stage-1 loop
    logic [ocra_pkg::COLOR_W-1:0] w_child [ocra_pkg::CHILD_INPUTS];

    assign w_child[0] = i_item.child_color_0;
    assign w_child[1] = i_item.child_color_1;
    assign w_child[2] = i_item.child_color_2;
    assign w_child[3] = i_item.child_color_3;
    assign w_child[4] = i_item.child_color_4;
    assign w_child[5] = i_item.child_color_5;
    assign w_child[6] = i_item.child_color_6;
    assign w_child[7] = i_item.child_color_7;

    // ---------------- stage 1: squares and set count ----------------
    logic [CHILD_COUNT-1:0] w_set;
    logic [SQ_W-1:0]        n_sq [CHILD_COUNT][NCH];

    logic                   r_vld1;
    logic                   r_has1;
    logic [ocra_pkg::COLOR_W-1:0] r_own1;
    logic [CNT_W-1:0]       r_cnt1;
    logic [SQ_W-1:0]        r_sq [CHILD_COUNT][NCH];

    always_comb begin
        for (int i = 0; i < CHILD_COUNT; i++) begin
            w_set[i] = (w_child[i] != '0);
            for (int c = 0; c < NCH; c++) begin
                // unset children hold zero in every channel, so the square is zero
                n_sq[i][c] = SQ_W'(w_child[i][CH_W*c +: CH_W])
                           * SQ_W'(w_child[i][CH_W*c +: CH_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= accept;
        end
        r_has1 <= i_item.has_children;
        r_own1 <= i_item.own_color;
        r_cnt1 <= CNT_W'($countones(w_set));
        r_sq   <= n_sq;
    end

    // ---------------- stage 2: per-channel square sums ----------------
    logic [SUM_W-1:0] n_sum [NCH];

    logic                   r_vld2;
    logic                   r_has2;
    logic [ocra_pkg::COLOR_W-1:0] r_own2;
    logic [CNT_W-1:0]       r_cnt2;
    logic [SUM_W-1:0]       r_sum [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_sum[c] = '0;
            for (int i = 0; i < CHILD_COUNT; i++) begin
                n_sum[c] = n_sum[c] + SUM_W'(r_sq[i][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_has2 <= r_has1;
        r_own2 <= r_own1;
        r_cnt2 <= r_cnt1;
        r_sum  <= n_sum;
    end

    // ---------------- stage 3: mean = sum * ceil(2^23/n) >> 23 ----------------
    logic [ocra_pkg::RECIP_W-1:0] w_recip;
    logic [PROD_W-1:0]            w_prod [NCH];

    logic                   r_vld3;
    logic                   r_has3;
    logic [ocra_pkg::COLOR_W-1:0] r_own3;
    logic [SQ_W-1:0]        r_mean [NCH];

    assign w_recip = ocra_pkg::recip(ocra_pkg::CNT_MAX_W'(r_cnt2));

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_prod[c] = PROD_W'(r_sum[c]) * PROD_W'(w_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
        r_has3 <= r_has2;
        r_own3 <= r_own2;
        for (int c = 0; c < NCH; c++) begin
            // mean <= 65025, fits 16 bits; zero count gives zero
            r_mean[c] <= w_prod[c][ocra_pkg::RECIP_SHIFT +: SQ_W];
        end
    end

    // ---------------- stage 4: root, upper four bit-steps ----------------
    logic [RT_W-1:0] n_rem4  [NCH];
    logic [RT_W-1:0] n_root4 [NCH];

    logic                   r_vld4;
    logic                   r_has4;
    logic [ocra_pkg::COLOR_W-1:0] r_own4;
    logic [RT_W-1:0]        r_rem4  [NCH];
    logic [RT_W-1:0]        r_root4 [NCH];

    always_comb begin
        logic [RT_W-1:0] rem;
        logic [RT_W-1:0] root;
        logic [RT_W-1:0] b;
        for (int c = 0; c < NCH; c++) begin
            rem  = RT_W'(r_mean[c]);
            root = '0;
            for (int k = 0; k < 4; k++) begin
                b = RT_W'(1) << (SQ_W - 2 - 2 * k);
                if (rem >= root + b) begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
            end
            n_rem4[c]  = rem;
            n_root4[c] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
        r_has4  <= r_has3;
        r_own4  <= r_own3;
        r_rem4  <= n_rem4;
        r_root4 <= n_root4;
    end

    // ---------------- stage 5: root, lower four bit-steps, output mux ----------------
    logic [CH_W-1:0] w_rt [NCH];
    ocra_pkg::t_out_word n_result;

    logic                r_strobe;
    ocra_pkg::t_out_word r_result;

    always_comb begin
        logic [RT_W-1:0] rem;
        logic [RT_W-1:0] root;
        logic [RT_W-1:0] b;
        for (int c = 0; c < NCH; c++) begin
            rem  = r_rem4[c];
            root = r_root4[c];
            for (int k = 4; k < 8; k++) begin
                b = RT_W'(1) << (SQ_W - 2 - 2 * k);
                if (rem >= root + b) begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
            end
            w_rt[c] = root[CH_W-1:0];
        end
    end

    always_comb begin
        if (r_has4) begin
            n_result.red_out   = w_rt[0];
            n_result.green_out = w_rt[1];
            n_result.blue_out  = w_rt[2];
        end else begin
            n_result.red_out   = r_own4[CH_W*0 +: CH_W];
            n_result.green_out = r_own4[CH_W*1 +: CH_W];
            n_result.blue_out  = r_own4[CH_W*2 +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld4;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---------------- assertions ----------------
    // o_strobe is registered from the accept flag through r_vld1, r_vld2, r_vld3, r_vld4 and r_strobe.
    `OCRA_ASSERT_NEXT(a_accept_gives_strobe, i_clk, i_rst_n, accept, ##4 o_strobe,
        "accepted word produced no result five edges later")
    `OCRA_ASSERT_IMPL(a_strobe_has_source, i_clk, i_rst_n, o_strobe, $past(accept, 5),
        "result strobe without an accepted word five edges earlier")
    `OCRA_ASSERT_IMPL(a_passthrough, i_clk, i_rst_n,
        o_strobe && !$past(i_item.has_children, 5),
        (o_result == $past(i_item.own_color, 5)),
        "childless node did not return its own color")
    `OCRA_ASSERT_IMPL(a_no_set_child_zero, i_clk, i_rst_n,
        r_vld1 && r_has1 && (r_cnt1 == '0), ##4 (o_result == '0),
        "node without set children did not return zero")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// RMS color reduction of one octree inner node.
// Directed table first, then random nodes. Every result word is checked
// field by field against the oldest entry of the pending queue.
module testbench;

    localparam int NUM_CHILDREN = 8;        // DUT parameter under test
    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT  = 400000;   // watchdog limit on the whole run
    localparam int SETTLE_CYCLES = 12;      // covers the pipeline depth, extra margin

    typedef logic [ocra_pkg::COLOR_W-1:0] t_kid_set [ocra_pkg::CHILD_INPUTS];

    // One row of the directed table. Rows with a typed result skip the
    // predictor; the rest are predicted.
    typedef struct {
        ocra_pkg::t_in_word  node;
        bit                  typed;
        ocra_pkg::t_out_word color;
    } t_node_row;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    ocra_pkg::t_in_word  i_item  = '0;
    logic                o_strobe;
    ocra_pkg::t_out_word o_result;

    ocra_pkg::t_out_word rms_expected[$];   // colors still owed by the DUT, oldest first
    t_node_row           node_table[$];

    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned words_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned passthru_words = 0;
    int unsigned empty_words    = 0;

    always #4 i_clk = ~i_clk;

    octree_child_rms_color_average #(
        .CHILD_COUNT(NUM_CHILDREN)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // ------------------------------------------------------------------
    // Node packing helpers
    // ------------------------------------------------------------------

    function automatic logic [ocra_pkg::COLOR_W-1:0] child_of(input ocra_pkg::t_in_word w,
                                                              input int idx);
        case (idx)
            0:       return w.child_color_0;
            1:       return w.child_color_1;
            2:       return w.child_color_2;
            3:       return w.child_color_3;
            4:       return w.child_color_4;
            5:       return w.child_color_5;
            6:       return w.child_color_6;
            default: return w.child_color_7;
        endcase
    endfunction

    function automatic ocra_pkg::t_in_word pack_node(input bit has,
                                                     input logic [ocra_pkg::COLOR_W-1:0] own,
                                                     input t_kid_set kids);
        ocra_pkg::t_in_word w;
        w.has_children  = has;
        w.own_color     = own;
        w.child_color_0 = kids[0];
        w.child_color_1 = kids[1];
        w.child_color_2 = kids[2];
        w.child_color_3 = kids[3];
        w.child_color_4 = kids[4];
        w.child_color_5 = kids[5];
        w.child_color_6 = kids[6];
        w.child_color_7 = kids[7];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Largest r with r*r <= q, built from the top bit down.
    function automatic logic [ocra_pkg::CHAN_W-1:0] floor_root(input int unsigned q);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int k = ocra_pkg::CHAN_W - 1; k >= 0; k--) begin
            t = r | (1 << k);
            if (t * t <= q)
                r = t;
        end
        return r[ocra_pkg::CHAN_W-1:0];
    endfunction

    // Root mean square per channel over the set children; pass-through
    // when the node has no children, zero when no child is set.
    function automatic ocra_pkg::t_out_word rms_predict(input ocra_pkg::t_in_word w);
        ocra_pkg::t_out_word           res;
        logic [ocra_pkg::COLOR_W-1:0]  kid;
        logic [ocra_pkg::CHAN_W-1:0]   ch_val;
        logic [ocra_pkg::CHAN_W-1:0]   roots[3];
        int unsigned                   sq_sum[3];
        int unsigned                   set_kids;
        int                            span;
        set_kids = 0;
        sq_sum   = '{0, 0, 0};
        span     = (NUM_CHILDREN > ocra_pkg::CHILD_INPUTS) ? ocra_pkg::CHILD_INPUTS
                                                           : NUM_CHILDREN;
        if (!w.has_children) begin
            res.red_out   = w.own_color[7:0];
            res.green_out = w.own_color[15:8];
            res.blue_out  = w.own_color[23:16];
            return res;
        end
        for (int i = 0; i < span; i++) begin
            kid = child_of(w, i);
            if (kid != '0) begin
                set_kids++;
                for (int ch = 0; ch < 3; ch++) begin
                    ch_val     = kid[ocra_pkg::CHAN_W*ch +: ocra_pkg::CHAN_W];
                    sq_sum[ch] += ch_val * ch_val;
                end
            end
        end
        for (int ch = 0; ch < 3; ch++)
            roots[ch] = (set_kids == 0) ? '0 : floor_root(sq_sum[ch] / set_kids);
        res.red_out   = roots[0];
        res.green_out = roots[1];
        res.blue_out  = roots[2];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Mix of saturated, single-channel, 0/FF-per-channel, tiny red-only and free colors.
    function automatic logic [ocra_pkg::COLOR_W-1:0] random_color();
        logic [ocra_pkg::COLOR_W-1:0] c;
        int unsigned                  mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: c = '1;
            1: begin
                c = '0;
                c[ocra_pkg::CHAN_W*$urandom_range(0, 2) +: ocra_pkg::CHAN_W] =
                    $urandom_range(1, 255);
            end
            2: begin
                for (int ch = 0; ch < 3; ch++)
                    c[ocra_pkg::CHAN_W*ch +: ocra_pkg::CHAN_W] =
                        $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            3: c = $urandom_range(1, 7);    // tiny values, red only
            default: c = $urandom;
        endcase
        return c;
    endfunction

    // Mostly nodes with children; child density is drawn per node so that
    // every set count from zero to eight comes up.
    function automatic ocra_pkg::t_in_word random_node();
        t_kid_set    kids;
        int unsigned density;
        bit          has;
        has     = ($urandom_range(0, 9) != 0);
        density = $urandom_range(0, 8);
        for (int i = 0; i < ocra_pkg::CHILD_INPUTS; i++)
            kids[i] = ($urandom_range(1, 8) <= density) ? random_color() : '0;
        return pack_node(has, $urandom, kids);
    endfunction

    // Sender gaps: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    task automatic add_row(input bit has, input logic [ocra_pkg::COLOR_W-1:0] own,
                           input t_kid_set kids, input bit typed,
                           input logic [ocra_pkg::COLOR_W-1:0] color);
        t_node_row row;
        row.node   = pack_node(has, own, kids);
        row.typed  = typed;
        row.color  = color;
        node_table = {node_table, row};
    endtask

    // Present one word and hold it until the accepting edge; the expected
    // color is queued at that edge.
    task automatic send_word(input ocra_pkg::t_in_word w, input bit typed,
                             input ocra_pkg::t_out_word color);
        bit                  any_set;
        ocra_pkg::t_out_word want;
        any_set = 1'b0;
        i_item <= w;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        want         = typed ? color : rms_predict(w);
        rms_expected = {rms_expected, want};
        words_sent++;
        for (int i = 0; i < NUM_CHILDREN && i < ocra_pkg::CHILD_INPUTS; i++)
            if (child_of(w, i) != '0)
                any_set = 1'b1;
        if (!w.has_children)
            passthru_words++;
        else if (!any_set)
            empty_words++;
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the sender off until every queued color has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (rms_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("cycle %0d: %s mismatch, got %0h want %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: a strobed word is taken at the edge that ends its
    // cycle, so sampling at the edge sees the word of the cycle just ended.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        ocra_pkg::t_out_word want;
        if (i_rst_n && o_strobe === 1'b1) begin
            results_seen++;
            if (rms_expected.size() == 0) begin
                report_mismatch("unexpected result", o_result, 0);
            end else begin
                want = rms_expected.pop_front();
                if (o_result.red_out !== want.red_out)
                    report_mismatch("red_out", o_result.red_out, want.red_out);
                if (o_result.green_out !== want.green_out)
                    report_mismatch("green_out", o_result.green_out, want.green_out);
                if (o_result.blue_out !== want.blue_out)
                    report_mismatch("blue_out", o_result.blue_out, want.blue_out);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors still pending",
                     cycle_count, rms_expected.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_kid_set none;
        t_kid_set full;
        t_kid_set kids;
        none = '{default: '0};
        full = '{default: 24'hFFFFFF};

        // Pass-through: own color returned as is, zero included, children
        // ignored whatever they hold.
        add_row(1'b0, 24'h000000, none, 1'b1, 24'h000000);
        add_row(1'b0, 24'hFFFFFF, none, 1'b1, 24'hFFFFFF);
        add_row(1'b0, 24'h123456, full, 1'b1, 24'h123456);
        kids = '{24'h0000FF, 24'h000000, 24'h00FF00, 24'h000000,
                 24'hFF0000, 24'h000000, 24'h010101, 24'h000000};
        add_row(1'b0, 24'hA5C30F, kids, 1'b1, 24'hA5C30F);
        // No set child: zero, even with a bright own color.
        add_row(1'b1, 24'hFFFFFF, none, 1'b1, 24'h000000);
        // Saturated children, all and single.
        add_row(1'b1, 24'h000000, full, 1'b1, 24'hFFFFFF);
        kids = none; kids[0] = 24'hFFFFFF;
        add_row(1'b1, 24'h000000, kids, 1'b1, 24'hFFFFFF);
        // A lone child comes back unchanged.
        kids = none; kids[7] = 24'h010203;
        add_row(1'b1, 24'h55AA55, kids, 1'b1, 24'h010203);
        kids = none; kids[3] = 24'h000001;
        add_row(1'b1, 24'h000000, kids, 1'b1, 24'h000001);
        kids = none; kids[4] = 24'h800000;
        add_row(1'b1, 24'h000000, kids, 1'b1, 24'h800000);
        // Equal children: mean of squares is exact.
        kids = '{default: 24'h010101};
        add_row(1'b1, 24'h000000, kids, 1'b1, 24'h010101);
        // Predicted rows: counts 2, 3 and 5..8, separate channels, rounding edges.
        kids = none; kids[0] = 24'hFFFFFF; kids[7] = 24'h000001;
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);
        kids = none; kids[0] = 24'h0000FF; kids[1] = 24'h00FF00; kids[2] = 24'hFF0000;
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);
        kids = '{24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001,
                 24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF};
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);
        kids = '{24'h102030, 24'h405060, 24'h708090, 24'hA0B0C0,
                 24'hD0E0F0, 24'h000000, 24'h000000, 24'h000000};
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);
        kids = '{24'hFEFEFE, 24'h000100, 24'h010000, 24'h7F7F7F,
                 24'h808080, 24'hFFFFFF, 24'h000000, 24'h000000};
        add_row(1'b1, 24'hFFFFFF, kids, 1'b0, '0);
        kids = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000001};
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);
        kids = '{24'hFF0001, 24'h01FF00, 24'h0001FF, 24'hFF0001,
                 24'h01FF00, 24'h0001FF, 24'hFF0001, 24'h01FF00};
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);
        kids = '{24'h010101, 24'h020202, 24'h030303, 24'h040404,
                 24'h050505, 24'h060606, 24'h070707, 24'h080808};
        add_row(1'b1, 24'h000000, kids, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (node_table[r]) begin
            send_word(node_table[r].node, node_table[r].typed, node_table[r].color);
            idle_cycles(pick_gap());
        end
        drain_results();

        // Random part. Two points hold the sender until the pipe is empty;
        // every fourth block of a hundred words runs back to back.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_word(random_node(), 1'b0, '0);
            if (n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3)
                drain_results();
            else if ((n / 100) % 4 != 1)
                idle_cycles(pick_gap());
        end

        drain_results();
        // Watch for stray strobes past the last expected word.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d node words: %0d pass-through, %0d with no set child",
                 words_sent, passthru_words, empty_words);
        $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
